// ----- design/qst_pkg.sv -----
// Shared types, constants and helpers of the quad subdivision tessellator.
package qst_pkg;

  localparam int ATTR_COUNT   = 9;
  localparam int CORNER_COUNT = 4;
  localparam int ATTR_W       = 32;
  localparam int INDEX_W      = 17;
  localparam int QUAD_W       = 15;
  localparam int LEVEL_W      = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd4;

  // ceil(2^18 / 6): exact floor(k / 6) for every k below 2^17
  localparam logic [15:0] DIV6_RECIP = 16'd43691;
  localparam int          DIV6_SHIFT = 18;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_GEN  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STEP,
    BK_EMIT
  } bk_state_t;

  typedef logic [ATTR_COUNT-1:0][ATTR_W-1:0] corner_t;

  typedef struct packed {
    op_t                 op;
    logic [1:0]          slot;
    corner_t             attrs;
    logic [INDEX_W-1:0]  k;
    logic [QUAD_W-1:0]   quad;
    logic                err;
    logic [LEVEL_W-1:0]  steps;
  } qst_item_t;

  // Corner taken for each vertex of the two triangles of a quad.
  function automatic logic [1:0] tri_corner(input logic [2:0] rem);
    logic [1:0] c;
    case (rem)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd3;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  // floor((a + b) / 2) taken at 33 bits
  function automatic logic [ATTR_W-1:0] half_sum(input logic [ATTR_W-1:0] a,
                                                 input logic [ATTR_W-1:0] b);
    logic [ATTR_W:0] s;
    s = {a[ATTR_W-1], a} + {b[ATTR_W-1], b};
    return s[ATTR_W:1];
  endfunction

endpackage

// ----- design/quad_subdivision_tessellator.sv -----
// Top level of the quad subdivision tessellator.
// Flow: a generate request waits in the queue, starts the engine from idle,
//   runs steps halvings, steps = clamped level - 1 (one halving of all 36
//   corner words per cycle), and is emitted once the result register is free.
//   The engine takes requests only in idle; a 2-entry queue absorbs the rest.
// Reset: clears queue, engine state and result valid; level returns to 4;
//   corner registers stay undefined until loaded.
module quad_subdivision_tessellator #(
  parameter int MAX_LEVEL = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [1:0]  corner_slot,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_u,
  input  logic [31:0] in_v,
  input  logic [31:0] in_r,
  input  logic [31:0] in_g,
  input  logic [31:0] in_b,
  input  logic [31:0] in_a,
  input  logic [16:0] vertex_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_u,
  output logic [31:0] out_v,
  output logic [31:0] out_r,
  output logic [31:0] out_g,
  output logic [31:0] out_b,
  output logic [31:0] out_a,
  output logic        index_error
);
  import qst_pkg::*;

  logic [LEVEL_W-1:0] subdivision_level;
  corner_t            in_attrs;
  corner_t            out_attr;
  qst_item_t          push_item;
  qst_item_t          head_item;
  logic               push;
  logic               q_full;
  logic               head_valid;
  logic               pop;

  // Level register; the host must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      subdivision_level <= LEVEL_RESET;
    end else if (cfg_we) begin
      subdivision_level <= cfg_wdata;
    end
  end

  // Pack the nine attributes in x, y, z, u, v, r, g, b, a order.
  assign in_attrs[0] = in_x;
  assign in_attrs[1] = in_y;
  assign in_attrs[2] = in_z;
  assign in_attrs[3] = in_u;
  assign in_attrs[4] = in_v;
  assign in_attrs[5] = in_r;
  assign in_attrs[6] = in_g;
  assign in_attrs[7] = in_b;
  assign in_attrs[8] = in_a;

  // Front end: classify the request, find the quad number and range check.
  qst_front #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .corner_slot  (corner_slot),
    .attrs        (in_attrs),
    .vertex_index (vertex_index),
    .level        (subdivision_level),
    .q_full       (q_full),
    .push         (push),
    .item         (push_item)
  );

  // Hold classified requests in order so loads never pass generates.
  qst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back end: write corners, or walk the base-4 digits and emit the vertex.
  qst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_attr   (out_attr),
    .out_err    (index_error)
  );

  assign out_x = out_attr[0];
  assign out_y = out_attr[1];
  assign out_z = out_attr[2];
  assign out_u = out_attr[3];
  assign out_v = out_attr[4];
  assign out_r = out_attr[5];
  assign out_g = out_attr[6];
  assign out_b = out_attr[7];
  assign out_a = out_attr[8];

  // An out-of-range vertex carries all-zero attributes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> out_x == '0 && out_y == '0 && out_z == '0 &&
      out_u == '0 && out_v == '0 && out_r == '0 && out_g == '0 && out_b == '0 &&
      out_a == '0)
    else $error("index error result with nonzero attributes");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Backpressure at the input only when the queue holds requests.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> head_valid)
    else $error("input stalled with empty queue");

  // The engine never drains a request the queue does not have.
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- design/qst_front.sv -----
// Front end: accepts requests, clamps the level, splits the vertex index.
module qst_front #(
  parameter int MAX_LEVEL = 8
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            opcode,
  input  logic [1:0]                      corner_slot,
  input  qst_pkg::corner_t                attrs,
  input  logic [qst_pkg::INDEX_W-1:0]     vertex_index,
  input  logic [qst_pkg::LEVEL_W-1:0]     level,
  input  logic                            q_full,
  output logic                            push,
  output qst_pkg::qst_item_t              item
);
  import qst_pkg::*;

  logic [LEVEL_W-1:0]          steps;
  logic [INDEX_W+15:0]         prod;
  logic [QUAD_W-1:0]           quad;
  logic [QUAD_W-1:0]           high_digits;

  always_comb begin
    if (level == '0) begin
      steps = '0;
    end else if (level > LEVEL_W'(MAX_LEVEL)) begin
      steps = LEVEL_W'(MAX_LEVEL - 1);
    end else begin
      steps = level - LEVEL_W'(1);
    end
  end

  assign prod        = vertex_index * DIV6_RECIP;
  assign quad        = prod[DIV6_SHIFT +: QUAD_W];
  // k is out of range exactly when the quad number has digits above the level
  assign high_digits = quad >> {steps, 1'b0};

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    item.op    = op_t'(opcode);
    item.slot  = corner_slot;
    item.attrs = attrs;
    item.k     = vertex_index;
    item.quad  = quad;
    item.err   = (high_digits != '0);
    item.steps = steps;
  end

endmodule

// ----- design/qst_queue.sv -----
// Two-entry request queue between the front end and the subdivision engine.
module qst_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qst_pkg::qst_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output qst_pkg::qst_item_t head_item
);
  import qst_pkg::*;

  qst_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/qst_back.sv -----
// Back end: corner registers, one subdivision step per cycle, result register.
module qst_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  qst_pkg::qst_item_t  head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output qst_pkg::corner_t    out_attr,
  output logic                out_err
);
  import qst_pkg::*;

  typedef struct packed {
    logic pop;
    logic load_wr;
    logic start;
    logic step;
    logic emit;
  } bk_ctl_t;

  bk_state_t              state;
  bk_state_t              state_next;
  bk_ctl_t                ctl;

  corner_t                corners [CORNER_COUNT];
  corner_t                cur     [CORNER_COUNT];
  corner_t                nxt     [CORNER_COUNT];
  logic [QUAD_W-1:0]      quad;
  logic [LEVEL_W-1:0]     cnt;
  logic [2:0]             rem;
  logic                   err;
  logic [INDEX_W-1:0]     quad6;
  logic [INDEX_W-1:0]     rem_full;
  logic [QUAD_W-1:0]      digit_word;
  logic [1:0]             digit;
  logic                   out_free;

  assign out_free = !out_valid || out_ready;

  // k mod 6 from the quad number: k - 6 * quad
  assign quad6    = {head_item.quad, 2'b00} + {1'b0, head_item.quad, 1'b0};
  assign rem_full = head_item.k - quad6;

  assign digit_word = quad >> {cnt - LEVEL_W'(1), 1'b0};
  assign digit      = digit_word[1:0];

  always_comb begin
    for (int c = 0; c < CORNER_COUNT; c++) begin
      for (int a = 0; a < ATTR_COUNT; a++) begin
        nxt[c][a] = half_sum(cur[digit & 2'(c)][a], cur[digit | 2'(c)][a]);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head_valid && head_item.op == OP_GEN) begin
          state_next = (head_item.steps == '0) ? BK_EMIT : BK_STEP;
        end
      end
      BK_STEP: begin
        if (cnt == LEVEL_W'(1)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      BK_IDLE: begin
        ctl.pop     = head_valid;
        ctl.load_wr = head_valid && head_item.op == OP_LOAD;
        ctl.start   = head_valid && head_item.op == OP_GEN;
      end
      BK_STEP: ctl.step = 1'b1;
      BK_EMIT: ctl.emit = out_free;
      default: ctl = '0;
    endcase
  end

  assign pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_wr) begin
      corners[head_item.slot] <= head_item.attrs;
    end
    if (ctl.start) begin
      cur  <= corners;
      quad <= head_item.quad;
      cnt  <= head_item.steps;
      rem  <= rem_full[2:0];
      err  <= head_item.err;
    end else if (ctl.step) begin
      cur <= nxt;
      cnt <= cnt - LEVEL_W'(1);
    end
    if (ctl.emit) begin
      out_attr <= err ? '0 : cur[tri_corner(rem)];
      out_err  <= err;
    end
  end

endmodule

// ----- bench/qst_vertex_checker.sv -----
// Checker for the quad subdivision tessellator: mirrors corners and level, predicts vertices.
module qst_vertex_checker #(
  parameter int MAX_LEVEL = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [qst_pkg::LEVEL_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        opcode,
  input  logic [1:0]                  corner_slot,
  input  logic [31:0]                 in_x,
  input  logic [31:0]                 in_y,
  input  logic [31:0]                 in_z,
  input  logic [31:0]                 in_u,
  input  logic [31:0]                 in_v,
  input  logic [31:0]                 in_r,
  input  logic [31:0]                 in_g,
  input  logic [31:0]                 in_b,
  input  logic [31:0]                 in_a,
  input  logic [qst_pkg::INDEX_W-1:0] vertex_index,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [31:0]                 out_x,
  input  logic [31:0]                 out_y,
  input  logic [31:0]                 out_z,
  input  logic [31:0]                 out_u,
  input  logic [31:0]                 out_v,
  input  logic [31:0]                 out_r,
  input  logic [31:0]                 out_g,
  input  logic [31:0]                 out_b,
  input  logic [31:0]                 out_a,
  input  logic                        index_error,
  output int                          fail_count,
  output int                          pending,
  output int                          vertices_seen,
  output int                          range_errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import qst_pkg::*;

  typedef struct packed {
    corner_t attr;
    logic    bad_index;
  } vertex_t;

  localparam int TRI_CORNER [6] = '{0, 1, 2, 3, 2, 1};

  corner_t                        in_word;
  corner_t                        out_word;
  corner_t [CORNER_COUNT-1:0]     corner_bank = '0;
  logic [LEVEL_W-1:0]             level = LEVEL_RESET;
  vertex_t                        expected_vertices [$];
  vertex_t                        want;
  int                             failures = 0;
  int                             vertex_count = 0;
  int                             range_count = 0;
  string                          attr_tag [ATTR_COUNT] =
                                    '{"x", "y", "z", "u", "v", "r", "g", "b", "a"};

  assign in_word  = {in_a, in_b, in_g, in_r, in_v, in_u, in_z, in_y, in_x};
  assign out_word = {out_a, out_b, out_g, out_r, out_v, out_u, out_z, out_y, out_x};

  // Walk the base-4 digits of the quad number, halving every corner once per digit.
  function automatic vertex_t subdivide_vertex(input logic [INDEX_W-1:0] k,
                                               input logic [LEVEL_W-1:0] lvl);
    vertex_t     v;
    int unsigned depth;
    int unsigned span;
    int unsigned quad;
    int unsigned sel;
    int unsigned st;
    int          c;
    int          a;
    longint      sum;
    corner_t [CORNER_COUNT-1:0] cur;
    corner_t [CORNER_COUNT-1:0] nxt;
    if (lvl == 0)
      depth = 0;
    else if (lvl > MAX_LEVEL)
      depth = MAX_LEVEL - 1;
    else
      depth = lvl - 1;
    span = 6 << (2 * depth);
    v = '0;
    if (k >= span) begin
      v.bad_index = 1'b1;
      return v;
    end
    cur  = corner_bank;
    nxt  = '0;
    quad = k / 6;
    for (st = 0; st < depth; st++) begin
      sel = (quad >> (2 * (depth - 1 - st))) & 3;
      for (c = 0; c < CORNER_COUNT; c++) begin
        for (a = 0; a < ATTR_COUNT; a++) begin
          sum = longint'($signed(cur[sel & c][a])) + longint'($signed(cur[sel | c][a]));
          nxt[c][a] = 32'(sum >>> 1);
        end
      end
      cur = nxt;
    end
    v.attr = cur[TRI_CORNER[k % 6]];
    return v;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    failures++;
    if (failures <= 10)
      $display("%0t: vertex %0d field %s: expected %h, got %h",
               $realtime, vertex_count, what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_vertices.delete();
      level = LEVEL_RESET;
    end else begin
      if (cfg_we)
        level = cfg_wdata;
      if (in_valid && in_ready) begin
        if (opcode == OP_LOAD)
          corner_bank[corner_slot] = in_word;
        else
          expected_vertices.push_back(subdivide_vertex(vertex_index, level));
      end
      if (out_valid && out_ready) begin
        if (expected_vertices.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: vertex result with no generate request pending", $realtime);
        end else begin
          want = expected_vertices.pop_front();
          for (int a = 0; a < ATTR_COUNT; a++)
            if (out_word[a] !== want.attr[a])
              note_mismatch(attr_tag[a], want.attr[a], out_word[a]);
          if (index_error !== want.bad_index)
            note_mismatch("index_error", 32'(want.bad_index), 32'(index_error));
          if (want.bad_index)
            range_count++;
          vertex_count++;
        end
      end
    end
    // Publish on the edge so the stimulus side always reads settled values.
    pending           <= expected_vertices.size();
    fail_count        <= failures;
    vertices_seen     <= vertex_count;
    range_errors_seen <= range_count;
  end

endmodule

// ----- bench/quad_subdivision_tessellator_test.sv -----
// Testbench top of the quad subdivision tessellator: stimulus, stalls and the verdict.
module quad_subdivision_tessellator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qst_pkg::*;

  localparam int MAX_LEVEL        = 8;
  localparam int PHASES           = 12;
  localparam int RANDOM_PER_PHASE = 156;
  localparam int HOLD_CYCLES      = 80;
  localparam int INDEX_TOP        = (1 << INDEX_W) - 1;
  // Tail wait: covers the longest generate, its halvings plus decode and emit.
  localparam int TAIL_CYCLES      = 2 * MAX_LEVEL + 4;

  // Level per phase; phase 0 runs on the reset value, the rest write the register.
  // Zero and values above the maximum exercise the clamping on both ends.
  localparam logic [LEVEL_W-1:0] LEVEL_PLAN [PHASES] =
    '{4'd4, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8};

  // Corner words that stress the 33-bit half sum: both extremes, minus one, plus one.
  localparam logic [31:0] EXTREME [4] =
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001};

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_we       = 1'b0;
  logic [LEVEL_W-1:0] cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  op_t                opcode       = OP_LOAD;
  logic [1:0]         corner_slot  = '0;
  logic [31:0]        in_x         = '0;
  logic [31:0]        in_y         = '0;
  logic [31:0]        in_z         = '0;
  logic [31:0]        in_u         = '0;
  logic [31:0]        in_v         = '0;
  logic [31:0]        in_r         = '0;
  logic [31:0]        in_g         = '0;
  logic [31:0]        in_b         = '0;
  logic [31:0]        in_a         = '0;
  logic [INDEX_W-1:0] vertex_index = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [31:0]        out_x;
  logic [31:0]        out_y;
  logic [31:0]        out_z;
  logic [31:0]        out_u;
  logic [31:0]        out_v;
  logic [31:0]        out_r;
  logic [31:0]        out_g;
  logic [31:0]        out_b;
  logic [31:0]        out_a;
  logic               index_error;

  int fail_count;
  int pending;
  int vertices_seen;
  int range_errors_seen;

  // Idle odds in percent for each side, and the request for a long output hold-off.
  int   tx_idle_pct  = 0;
  int   rx_idle_pct  = 0;
  logic hold_start   = 1'b0;
  int   hold_left    = 0;
  int   requests_sent = 0;

  always #2ns clk = ~clk;

  quad_subdivision_tessellator #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .corner_slot (corner_slot),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .in_u        (in_u),
    .in_v        (in_v),
    .in_r        (in_r),
    .in_g        (in_g),
    .in_b        (in_b),
    .in_a        (in_a),
    .vertex_index(vertex_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_u       (out_u),
    .out_v       (out_v),
    .out_r       (out_r),
    .out_g       (out_g),
    .out_b       (out_b),
    .out_a       (out_a),
    .index_error (index_error)
  );

  qst_vertex_checker #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .corner_slot      (corner_slot),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_z             (in_z),
    .in_u             (in_u),
    .in_v             (in_v),
    .in_r             (in_r),
    .in_g             (in_g),
    .in_b             (in_b),
    .in_a             (in_a),
    .vertex_index     (vertex_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_z            (out_z),
    .out_u            (out_u),
    .out_v            (out_v),
    .out_r            (out_r),
    .out_g            (out_g),
    .out_b            (out_b),
    .out_a            (out_a),
    .index_error      (index_error),
    .fail_count       (fail_count),
    .pending          (pending),
    .vertices_seen    (vertices_seen),
    .range_errors_seen(range_errors_seen)
  );

  // Result side: random back-pressure, or a long counted hold-off when asked for.
  // While held, the input queue fills up and the block must drop in_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Give up long after the slowest correct run could have finished.
  initial begin
    #2ms;
    $display("Timeout with %0d vertices still expected", pending);
    $display("Test completed with failures");
    $finish;
  end

  // Number of vertices the plane has at a given register value, clamped as the block does.
  function automatic int unsigned vertex_span(input logic [LEVEL_W-1:0] lvl);
    int unsigned depth;
    if (lvl == 0)
      depth = 0;
    else if (lvl > MAX_LEVEL)
      depth = MAX_LEVEL - 1;
    else
      depth = lvl - 1;
    return 6 << (2 * depth);
  endfunction

  // Random attribute words; some share of them taken from the extremes.
  function automatic corner_t random_words(input int extreme_pct);
    corner_t w;
    for (int a = 0; a < ATTR_COUNT; a++)
      w[a] = ($urandom_range(99) < extreme_pct) ? EXTREME[$urandom_range(3)] : $urandom;
    return w;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input op_t op, input logic [1:0] slot, input corner_t words,
                              input logic [INDEX_W-1:0] k);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    corner_slot  <= slot;
    in_x         <= words[0];
    in_y         <= words[1];
    in_z         <= words[2];
    in_u         <= words[3];
    in_v         <= words[4];
    in_r         <= words[5];
    in_g         <= words[6];
    in_b         <= words[7];
    in_a         <= words[8];
    vertex_index <= k;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    requests_sent++;
  endtask

  // Mostly in-range vertices, with corner reloads, boundary indexes and
  // out-of-range indexes mixed in; generate payload words are noise.
  task automatic random_request(input int unsigned span);
    int unsigned        pick;
    logic [INDEX_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_request(OP_LOAD, 2'($urandom_range(3)), random_words(20), INDEX_W'($urandom));
    end else begin
      if (pick < 65)
        k = INDEX_W'($urandom_range(span - 1, 0));
      else if (pick < 75)
        k = INDEX_W'(span - 3 + $urandom_range(5));
      else if (pick < 85)
        k = INDEX_W'($urandom_range(INDEX_TOP, span));
      else
        k = INDEX_W'($urandom_range(INDEX_TOP));
      send_request(OP_GEN, 2'($urandom), random_words(0), k);
    end
  endtask

  // Drop valid and wait for every vertex; optionally let a trailing load finish too.
  task automatic settle(input bit with_tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    if (with_tail)
      repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    corner_t            words;
    logic [LEVEL_W-1:0] lvl_now;
    int unsigned        span;
    int                 n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    lvl_now = LEVEL_RESET;

    for (int phase = 0; phase < PHASES; phase++) begin
      // Reprogram the level only while the block is drained.
      if (phase != 0) begin
        lvl_now = LEVEL_PLAN[phase];
        cfg_we    <= 1'b1;
        cfg_wdata <= lvl_now;
        @(posedge clk);
        cfg_we    <= 1'b0;
      end
      // Sender rarely idle and receiver mostly idle, then swapped, then free-running.
      case (phase / 4)
        0: begin
          tx_idle_pct <= 7;
          rx_idle_pct <= 76;
        end
        1: begin
          tx_idle_pct <= 76;
          rx_idle_pct <= 7;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      @(posedge clk);
      span = vertex_span(lvl_now);

      if (phase == 0) begin
        // Load all four corners first, so no vertex ever reads an empty corner.
        for (int c = 0; c < CORNER_COUNT; c++) begin
          for (int a = 0; a < ATTR_COUNT; a++)
            words[a] = EXTREME[(c + a) % 4];
          send_request(OP_LOAD, 2'(c), words, INDEX_W'($urandom));
        end
        // Every position of the two-triangle pattern of the first quad.
        for (int k = 0; k < 6; k++)
          send_request(OP_GEN, 2'($urandom), random_words(0), INDEX_W'(k));
        // Last vertex, first vertex past the end, and the all-ones index.
        send_request(OP_GEN, 2'd0, random_words(0), INDEX_W'(span - 1));
        send_request(OP_GEN, 2'd3, random_words(0), INDEX_W'(span));
        send_request(OP_GEN, 2'd1, random_words(0), INDEX_W'(INDEX_TOP));
        // Quads whose digits are all ones and all threes.
        send_request(OP_GEN, 2'd2, random_words(0), INDEX_W'(6 * 21 + 2));
        send_request(OP_GEN, 2'd0, random_words(0), INDEX_W'(6 * 63 + 4));
        // Reload one corner and read through it again.
        send_request(OP_LOAD, 2'd2, random_words(0), '0);
        send_request(OP_GEN, 2'd1, random_words(0), INDEX_W'(6 * 42 + 5));
        send_request(OP_GEN, 2'd3, random_words(0), INDEX_W'(6 * 10 + 3));
      end

      // Hold the result side off while requests keep coming.
      if (phase % 8 == 1) begin
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Halfway through, pause the sender until the block has emptied.
        if (n == RANDOM_PER_PHASE / 2)
          settle(1'b0);
        random_request(span);
      end
      settle(1'b1);
    end

    $display("Sent %0d requests over %0d level settings; checked %0d vertices, %0d of them",
             requests_sent, PHASES, vertices_seen, range_errors_seen);
    $display("out of range, under mixed stalls, a long output hold-off and drained pauses.");
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
design/qst_pkg.sv
design/qst_front.sv
design/qst_queue.sv
design/qst_back.sv
design/quad_subdivision_tessellator.sv
bench/qst_vertex_checker.sv
bench/quad_subdivision_tessellator_test.sv
